// ===== rtl/core/tflg_pkg.sv =====
// Shared types and constants for the throughput frequency lock governor.
`default_nettype none

package tflg_pkg;

  // Number of speed thresholds (lock levels above zero).
  localparam int unsigned NumLevels = 3;

  // Field widths.
  localparam int unsigned PktBytesW  = 16;
  localparam int unsigned AccumW     = 25;
  localparam int unsigned TriggerW   = 24;
  localparam int unsigned KbpsW      = 20;
  localparam int unsigned TimeoutW   = 16;
  localparam int unsigned LevelW     = 2;
  localparam int unsigned ElapsedW   = 32;
  localparam int unsigned CpuKhzW    = 20;
  localparam int unsigned DdrKhzW    = 17;
  localparam int unsigned MeasuredW  = 35;
  localparam int unsigned CfgIndexW  = 3;
  localparam int unsigned CfgDataW   = 24;

  // Divider: dividend is bytes * 8, one quotient bit per step.
  localparam int unsigned DividendW  = AccumW + 3;
  localparam int unsigned DivSteps   = DividendW;
  localparam int unsigned DivCntW    = $clog2(DivSteps);

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] RegTriggerBytes = 3'd0;
  localparam logic [CfgIndexW-1:0] RegLevel1Kbps   = 3'd1;
  localparam logic [CfgIndexW-1:0] RegLevel2Kbps   = 3'd2;
  localparam logic [CfgIndexW-1:0] RegLevel3Kbps   = 3'd3;
  localparam logic [CfgIndexW-1:0] RegReleaseMs    = 3'd4;
  localparam logic [CfgIndexW-1:0] RegDdrStart     = 3'd5;

  // Configuration reset values.
  localparam logic [TriggerW-1:0] TriggerReset  = 24'd655360;
  localparam logic [KbpsW-1:0]    Level1Reset   = 20'd8000;
  localparam logic [KbpsW-1:0]    Level2Reset   = 20'd16000;
  localparam logic [KbpsW-1:0]    Level3Reset   = 20'd28000;
  localparam logic [TimeoutW-1:0] ReleaseReset  = 16'd1000;
  localparam logic [LevelW-1:0]   DdrStartReset = 2'd3;

  // Frequency floors.
  localparam logic [CpuKhzW-1:0] CpuKhzL1   = 20'd600000;
  localparam logic [CpuKhzW-1:0] CpuKhzL2   = 20'd800000;
  localparam logic [CpuKhzW-1:0] CpuKhzL3   = 20'd900000;
  localparam logic [DdrKhzW-1:0] DdrKhzLock = 17'd120000;

  // Request codes.
  localparam logic ReqPacket = 1'b0;
  localparam logic ReqTick   = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StDiv   = 4'b0010,
    StLevel = 4'b0100,
    StFin   = 4'b1000
  } state_e;

  // Processor floor for a lock level.
  function automatic logic [CpuKhzW-1:0] cpu_khz_for(input logic [LevelW-1:0] lvl);
    logic [CpuKhzW-1:0] khz;
    unique case (lvl)
      2'd1:    khz = CpuKhzL1;
      2'd2:    khz = CpuKhzL2;
      2'd3:    khz = CpuKhzL3;
      default: khz = '0;
    endcase
    return khz;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/throughput_frequency_lock_governor.sv =====
// Throughput frequency lock governor: byte accounting, speed divide and lock control.
`default_nettype none

// Every transfer on the input side is either a packet (req_type_i = 0) whose byte
// count is added to an accumulator, or a one-millisecond tick (req_type_i = 1) that
// advances the elapsed-time counter and the lock release countdown. When the
// accumulator exceeds trigger_bytes it is cleared together with the elapsed time;
// with a nonzero elapsed time the speed bytes*8/ms (kbit/s) is computed and its
// level (thresholds exceeded up to the first miss, scanned upward), if nonzero,
// takes or refreshes the frequency lock. Exactly one result transfer leaves per
// input transfer. A tick, or a packet that starts no calculation, goes from idle
// to the finish step and back; a calculation first runs the divide and level steps,
// the restoring divider using its single 33-bit subtract-and-compare unit once per
// quotient bit. Input is stalled until the block is back in idle. A finished result
// sits in an output register, so a stalled output only holds the block once the
// next result is ready. Configuration writes are always taken (cfg_ready_o high).
module throughput_frequency_lock_governor (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration write channel
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [tflg_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  wire logic [tflg_pkg::CfgDataW-1:0]      cfg_data_i,
  // Input item channel
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               req_type_i,
  input  wire logic [tflg_pkg::PktBytesW-1:0]     packet_bytes_i,
  // Result channel
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    lock_active_o,
  output logic [tflg_pkg::LevelW-1:0]             lock_tier_o,
  output logic                                    ddr_lock_active_o,
  output logic [tflg_pkg::CpuKhzW-1:0]            cpu_min_khz_o,
  output logic [tflg_pkg::DdrKhzW-1:0]            ddr_min_khz_o,
  output logic                                    speed_valid_o,
  output logic [tflg_pkg::MeasuredW-1:0]          measured_kbps_o,
  output logic                                    level_changed_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [tflg_pkg::TriggerW-1:0] trigger_q;
  logic [tflg_pkg::KbpsW-1:0]    lvl1_q, lvl2_q, lvl3_q;
  logic [tflg_pkg::TimeoutW-1:0] release_q;
  logic [tflg_pkg::LevelW-1:0]   ddr_start_q;
  logic                          cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_q   <= tflg_pkg::TriggerReset;
      lvl1_q      <= tflg_pkg::Level1Reset;
      lvl2_q      <= tflg_pkg::Level2Reset;
      lvl3_q      <= tflg_pkg::Level3Reset;
      release_q   <= tflg_pkg::ReleaseReset;
      ddr_start_q <= tflg_pkg::DdrStartReset;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        tflg_pkg::RegTriggerBytes: trigger_q   <= cfg_data_i[tflg_pkg::TriggerW-1:0];
        tflg_pkg::RegLevel1Kbps:   lvl1_q      <= cfg_data_i[tflg_pkg::KbpsW-1:0];
        tflg_pkg::RegLevel2Kbps:   lvl2_q      <= cfg_data_i[tflg_pkg::KbpsW-1:0];
        tflg_pkg::RegLevel3Kbps:   lvl3_q      <= cfg_data_i[tflg_pkg::KbpsW-1:0];
        tflg_pkg::RegReleaseMs:    release_q   <= cfg_data_i[tflg_pkg::TimeoutW-1:0];
        tflg_pkg::RegDdrStart:     ddr_start_q <= cfg_data_i[tflg_pkg::LevelW-1:0];
        default: ;  // unmapped indexes are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and governor state
  // ---------------------------------------------------------------------------
  tflg_pkg::state_e state_q, state_d;

  logic [tflg_pkg::AccumW-1:0]   accum_q, accum_d;
  logic [tflg_pkg::ElapsedW-1:0] elapsed_q, elapsed_d;
  logic                          held_q, held_d;
  logic [tflg_pkg::LevelW-1:0]   level_q, level_d;
  logic [tflg_pkg::TimeoutW-1:0] countdown_q, countdown_d;

  // Per-item bookkeeping for the result
  logic                          old_held_q, old_held_d;
  logic [tflg_pkg::LevelW-1:0]   old_level_q, old_level_d;
  logic                          spd_valid_q, spd_valid_d;

  // Divider datapath: quo_q starts as the dividend and collects quotient bits
  logic [tflg_pkg::ElapsedW-1:0]  rem_q, rem_d;
  logic [tflg_pkg::DividendW-1:0] quo_q, quo_d;
  logic [tflg_pkg::ElapsedW-1:0]  div_q, div_d;
  logic [tflg_pkg::DivCntW-1:0]   cnt_q, cnt_d;

  // Output register
  logic                           out_valid_q, out_valid_d;
  logic                           o_active_q, o_ddr_q, o_spd_valid_q, o_changed_q;
  logic [tflg_pkg::LevelW-1:0]    o_level_q;
  logic [tflg_pkg::CpuKhzW-1:0]   o_cpu_q;
  logic [tflg_pkg::DdrKhzW-1:0]   o_ddrkhz_q;
  logic [tflg_pkg::MeasuredW-1:0] o_meas_q;
  logic                           out_load;

  logic                           in_xfer;
  logic [tflg_pkg::AccumW-1:0]    accum_sum;
  logic [tflg_pkg::ElapsedW:0]    trial;
  logic [tflg_pkg::ElapsedW:0]    trial_diff;
  logic                           trial_ge;
  logic [tflg_pkg::LevelW-1:0]    new_level;
  logic                           ddr_on;

  assign in_stall_o = (state_q != tflg_pkg::StIdle);
  assign in_xfer    = in_valid_i & ~in_stall_o;

  // Accumulator add wraps at its width
  assign accum_sum = accum_q + tflg_pkg::AccumW'(packet_bytes_i);

  // Shared subtract-and-compare: shift in the next dividend bit, try the divisor
  assign trial      = {rem_q, quo_q[tflg_pkg::DividendW-1]};
  assign trial_diff = trial - {1'b0, div_q};
  assign trial_ge   = ~trial_diff[tflg_pkg::ElapsedW];

  // Level: thresholds passed before the first one that is not passed
  always_comb begin
    new_level = 2'd0;
    if ({8'd0, quo_q} > {16'd0, lvl1_q}) begin
      new_level = 2'd1;
      if ({8'd0, quo_q} > {16'd0, lvl2_q}) begin
        new_level = 2'd2;
        if ({8'd0, quo_q} > {16'd0, lvl3_q}) begin
          new_level = 2'd3;
        end
      end
    end
  end

  // Load the output register once it is free or being drained this cycle
  assign out_load = (state_q == tflg_pkg::StFin) & (~out_valid_q | ~out_stall_i);
  assign ddr_on   = held_q & (level_q >= ddr_start_q);

  always_comb begin
    state_d     = state_q;
    accum_d     = accum_q;
    elapsed_d   = elapsed_q;
    held_d      = held_q;
    level_d     = level_q;
    countdown_d = countdown_q;
    old_held_d  = old_held_q;
    old_level_d = old_level_q;
    spd_valid_d = spd_valid_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    div_d       = div_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      tflg_pkg::StIdle: begin
        if (in_xfer) begin
          old_held_d  = held_q;
          old_level_d = level_q;
          spd_valid_d = 1'b0;
          state_d     = tflg_pkg::StFin;
          if (req_type_i == tflg_pkg::ReqPacket) begin
            accum_d = accum_sum;
            if (accum_sum > {1'b0, trigger_q}) begin
              // Take the window: clear both counters, divide if time has passed
              accum_d   = '0;
              elapsed_d = '0;
              if (elapsed_q != '0) begin
                rem_d   = '0;
                quo_d   = {accum_sum, 3'b000};
                div_d   = elapsed_q;
                cnt_d   = '0;
                state_d = tflg_pkg::StDiv;
              end
            end
          end else begin
            // Tick: saturate elapsed time, count down a held lock
            if (elapsed_q != '1) begin
              elapsed_d = elapsed_q + 1'b1;
            end
            if (held_q) begin
              if (countdown_q <= 16'd1) begin
                countdown_d = '0;
                held_d      = 1'b0;
                level_d     = '0;
              end else begin
                countdown_d = countdown_q - 1'b1;
              end
            end
          end
        end
      end
      tflg_pkg::StDiv: begin
        rem_d = trial_ge ? trial_diff[tflg_pkg::ElapsedW-1:0]
                         : trial[tflg_pkg::ElapsedW-1:0];
        quo_d = {quo_q[tflg_pkg::DividendW-2:0], trial_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == tflg_pkg::DivCntW'(tflg_pkg::DivSteps - 1)) begin
          state_d = tflg_pkg::StLevel;
        end
      end
      tflg_pkg::StLevel: begin
        spd_valid_d = 1'b1;
        if (new_level != '0) begin
          held_d      = 1'b1;
          level_d     = new_level;
          countdown_d = release_q;
        end
        state_d = tflg_pkg::StFin;
      end
      tflg_pkg::StFin: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = tflg_pkg::StIdle;
        end
      end
      default: state_d = tflg_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tflg_pkg::StIdle;
      accum_q     <= '0;
      elapsed_q   <= '0;
      held_q      <= 1'b0;
      level_q     <= '0;
      countdown_q <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      accum_q     <= accum_d;
      elapsed_q   <= elapsed_d;
      held_q      <= held_d;
      level_q     <= level_d;
      countdown_q <= countdown_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Datapath and result payload: no reset needed
  always_ff @(posedge clk_i) begin
    old_held_q  <= old_held_d;
    old_level_q <= old_level_d;
    spd_valid_q <= spd_valid_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    div_q       <= div_d;
    if (out_load) begin
      o_active_q    <= held_q;
      o_level_q     <= held_q ? level_q : '0;
      o_ddr_q       <= ddr_on;
      o_cpu_q       <= held_q ? tflg_pkg::cpu_khz_for(level_q) : '0;
      o_ddrkhz_q    <= ddr_on ? tflg_pkg::DdrKhzLock : '0;
      o_spd_valid_q <= spd_valid_q;
      o_meas_q      <= spd_valid_q ? tflg_pkg::MeasuredW'(quo_q) : '0;
      o_changed_q   <= (old_held_q != held_q) || (old_level_q != level_q);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign lock_active_o     = o_active_q;
  assign lock_tier_o       = o_level_q;
  assign ddr_lock_active_o = o_ddr_q;
  assign cpu_min_khz_o     = o_cpu_q;
  assign ddr_min_khz_o     = o_ddrkhz_q;
  assign speed_valid_o     = o_spd_valid_q;
  assign measured_kbps_o   = o_meas_q;
  assign level_changed_o   = o_changed_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tflg_pkg::StDiv) |-> (div_q != '0))
    else $error("divider running with zero divisor");

  a_unlocked_level_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !held_q |-> (level_q == '0))
    else $error("lock level nonzero while unlocked");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == tflg_pkg::StFin))
    else $error("result raised outside the finish step");

  a_fin_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == tflg_pkg::StFin) && out_valid_q && out_stall_i)
      |=> (state_q == tflg_pkg::StFin))
    else $error("finish step left while the output register was blocked");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && o_spd_valid_q)
      |-> (o_meas_q[tflg_pkg::MeasuredW-1:tflg_pkg::DividendW] == '0))
    else $error("measured speed exceeds dividend range");

endmodule

`default_nettype wire

// ===== verif/tb_throughput_frequency_lock_governor.sv =====
// Self-checking testbench for the throughput frequency lock governor.
module tb_throughput_frequency_lock_governor;
  timeunit 1ns;
  timeprecision 1ps;

  // Idle cycles granted after the last result before touching the registers;
  // covers the longest divide plus the result register.
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned MaxPrinted   = 40;

  // One result transfer, field by field.
  typedef struct packed {
    logic                           lock_active;
    logic [tflg_pkg::LevelW-1:0]    lock_tier;
    logic                           ddr_lock_active;
    logic [tflg_pkg::CpuKhzW-1:0]   cpu_min_khz;
    logic [tflg_pkg::DdrKhzW-1:0]   ddr_min_khz;
    logic                           speed_valid;
    logic [tflg_pkg::MeasuredW-1:0] measured_kbps;
    logic                           level_changed;
  } gov_result_t;

  // One input transfer: a packet or a millisecond tick.
  typedef struct packed {
    logic                           req_type;
    logic [tflg_pkg::PktBytesW-1:0] packet_bytes;
  } gov_req_t;

  // Clock, reset and block ports.
  logic                           clk_i;
  logic                           rst_ni = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [tflg_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [tflg_pkg::CfgDataW-1:0]  cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           req_type = 1'b0;
  logic [tflg_pkg::PktBytesW-1:0] packet_bytes = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           lock_active;
  logic [tflg_pkg::LevelW-1:0]    lock_tier;
  logic                           ddr_lock_active;
  logic [tflg_pkg::CpuKhzW-1:0]   cpu_min_khz;
  logic [tflg_pkg::DdrKhzW-1:0]   ddr_min_khz;
  logic                           speed_valid;
  logic [tflg_pkg::MeasuredW-1:0] measured_kbps;
  logic                           level_changed;

  // Traffic waiting to be sent and lock states waiting to be seen.
  gov_req_t    req_q[$];
  gov_result_t lock_state_q[$];

  // Handshake bookkeeping shared between the clocked processes; in_count and
  // out_count each have exactly one writer.
  int unsigned in_count  = 0;
  int unsigned out_count = 0;
  int unsigned err_count = 0;
  bit          src_fast  = 1'b0;
  bit          sink_fast = 1'b0;

  // Shadow of the governor: register copies and the accounting state.
  logic [tflg_pkg::TriggerW-1:0] m_trigger   = tflg_pkg::TriggerReset;
  logic [tflg_pkg::KbpsW-1:0]    m_thresh[tflg_pkg::NumLevels];
  logic [tflg_pkg::TimeoutW-1:0] m_release   = tflg_pkg::ReleaseReset;
  logic [tflg_pkg::LevelW-1:0]   m_ddr_start = tflg_pkg::DdrStartReset;
  logic [tflg_pkg::AccumW-1:0]   m_accum     = '0;
  logic [tflg_pkg::ElapsedW-1:0] m_elapsed   = '0;
  logic                          m_locked    = 1'b0;
  logic [tflg_pkg::LevelW-1:0]   m_level     = '0;
  logic [tflg_pkg::TimeoutW-1:0] m_countdown = '0;

  initial begin
    m_thresh[0] = tflg_pkg::Level1Reset;
    m_thresh[1] = tflg_pkg::Level2Reset;
    m_thresh[2] = tflg_pkg::Level3Reset;
  end

  throughput_frequency_lock_governor dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .req_type_i        (req_type),
    .packet_bytes_i    (packet_bytes),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .lock_active_o     (lock_active),
    .lock_tier_o       (lock_tier),
    .ddr_lock_active_o (ddr_lock_active),
    .cpu_min_khz_o     (cpu_min_khz),
    .ddr_min_khz_o     (ddr_min_khz),
    .speed_valid_o     (speed_valid),
    .measured_kbps_o   (measured_kbps),
    .level_changed_o   (level_changed)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Advance the shadow governor by one transfer and return the lock state
  // the block must report for it.
  function automatic gov_result_t step_governor(
      input logic rtype, input logic [tflg_pkg::PktBytesW-1:0] nbytes);
    gov_result_t                 r;
    logic                        was_locked;
    logic [tflg_pkg::LevelW-1:0] was_level;
    logic [63:0]                 speed;
    logic [31:0]                 dur;
    logic [tflg_pkg::LevelW-1:0] lvl;
    logic                        stop;
    was_locked = m_locked;
    was_level  = m_level;
    r = '0;
    if (rtype == tflg_pkg::ReqPacket) begin
      m_accum = m_accum + tflg_pkg::AccumW'(nbytes);
      // A zero-byte packet still compares against the trigger.
      if (m_accum > m_trigger) begin
        speed = {39'd0, m_accum} << 3;
        dur = m_elapsed;
        m_accum = '0;
        m_elapsed = '0;
        // No elapsed time: counters are cleared, the lock is left alone.
        if (dur != 0) begin
          speed = speed / {32'd0, dur};
          r.speed_valid = 1'b1;
          r.measured_kbps = speed[tflg_pkg::MeasuredW-1:0];
          // Count thresholds strictly passed, stopping at the first miss.
          lvl = '0;
          stop = 1'b0;
          for (int i = 0; i < tflg_pkg::NumLevels; i++) begin
            if (!stop && speed > {44'd0, m_thresh[i]}) lvl = tflg_pkg::LevelW'(i + 1);
            else stop = 1'b1;
          end
          if (lvl != 0) begin
            m_locked = 1'b1;
            m_level = lvl;
            m_countdown = m_release;
          end
        end
      end
    end else begin
      if (m_elapsed != '1) m_elapsed = m_elapsed + 1'b1;
      // Countdown of one or zero releases; unlocked ticks leave it alone.
      if (m_locked) begin
        if (m_countdown <= 1) begin
          m_countdown = '0;
          m_locked = 1'b0;
          m_level = '0;
        end else begin
          m_countdown = m_countdown - 1'b1;
        end
      end
    end
    r.lock_active = m_locked;
    r.lock_tier = m_locked ? m_level : '0;
    r.ddr_lock_active = m_locked && (m_level >= m_ddr_start);
    case (r.lock_tier)
      2'd1:    r.cpu_min_khz = tflg_pkg::CpuKhzL1;
      2'd2:    r.cpu_min_khz = tflg_pkg::CpuKhzL2;
      2'd3:    r.cpu_min_khz = tflg_pkg::CpuKhzL3;
      default: r.cpu_min_khz = '0;
    endcase
    r.ddr_min_khz = r.ddr_lock_active ? tflg_pkg::DdrKhzLock : '0;
    r.level_changed = (was_locked != m_locked) || (was_level != m_level);
    return r;
  endfunction

  function automatic int unsigned draw_gap(input bit fast);
    return fast ? 0 : $urandom_range(0, 7);
  endfunction

  // Packet length mix: both extremes, full range, and sizes up to a quarter of the trigger plus one.
  function automatic logic [tflg_pkg::PktBytesW-1:0] pick_len(
      input logic [tflg_pkg::CfgDataW-1:0] trig);
    int unsigned                    cap;
    logic [tflg_pkg::PktBytesW-1:0] len;
    cap = (trig >> 2) + 1;
    if (cap > 65535) cap = 65535;
    case ($urandom_range(0, 7))
      0:       len = '0;
      1:       len = '1;
      2, 3:    len = tflg_pkg::PktBytesW'($urandom_range(0, 65535));
      default: len = tflg_pkg::PktBytesW'($urandom_range(0, cap));
    endcase
    return len;
  endfunction

  task automatic report_error(input string msg);
    err_count++;
    if (err_count <= MaxPrinted) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] seen,
                             input logic [63:0] wanted);
    if (seen !== wanted)
      report_error($sformatf("%s got %0h, expected %0h", name, seen, wanted));
  endtask

  task automatic push_req(input logic rtype,
                          input logic [tflg_pkg::PktBytesW-1:0] nbytes);
    gov_req_t r;
    r.req_type = rtype;
    r.packet_bytes = nbytes;
    req_q.push_back(r);
  endtask

  // One register write; the shadow copy follows the same index decode.
  task automatic write_reg(input logic [tflg_pkg::CfgIndexW-1:0] idx,
                           input logic [tflg_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    case (idx)
      tflg_pkg::RegTriggerBytes: m_trigger   = val[tflg_pkg::TriggerW-1:0];
      tflg_pkg::RegLevel1Kbps:   m_thresh[0] = val[tflg_pkg::KbpsW-1:0];
      tflg_pkg::RegLevel2Kbps:   m_thresh[1] = val[tflg_pkg::KbpsW-1:0];
      tflg_pkg::RegLevel3Kbps:   m_thresh[2] = val[tflg_pkg::KbpsW-1:0];
      tflg_pkg::RegReleaseMs:    m_release   = val[tflg_pkg::TimeoutW-1:0];
      tflg_pkg::RegDdrStart:     m_ddr_start = val[tflg_pkg::LevelW-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [tflg_pkg::CfgDataW-1:0] trig,
                              input logic [tflg_pkg::KbpsW-1:0] t1,
                              input logic [tflg_pkg::KbpsW-1:0] t2,
                              input logic [tflg_pkg::KbpsW-1:0] t3,
                              input logic [tflg_pkg::TimeoutW-1:0] rel,
                              input logic [tflg_pkg::LevelW-1:0] ddr);
    write_reg(tflg_pkg::RegTriggerBytes, trig);
    write_reg(tflg_pkg::RegLevel1Kbps, tflg_pkg::CfgDataW'(t1));
    write_reg(tflg_pkg::RegLevel2Kbps, tflg_pkg::CfgDataW'(t2));
    write_reg(tflg_pkg::RegLevel3Kbps, tflg_pkg::CfgDataW'(t3));
    write_reg(tflg_pkg::RegReleaseMs, tflg_pkg::CfgDataW'(rel));
    write_reg(tflg_pkg::RegDdrStart, tflg_pkg::CfgDataW'(ddr));
  endtask

  // Hold until every queued item went in and every lock state came back,
  // then give the block its latency before anything else happens.
  task automatic settle();
    while (req_q.size() != 0 || in_valid || lock_state_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Sender: present items at the falling edge. After each transfer wait the
  // gap drawn for that item; now and then hold the next item until all
  // results are back so the block drains completely mid-phase.
  always @(negedge clk_i) begin : drive_proc
    int unsigned send_gap;
    int unsigned seen_in;
    int unsigned sent_count;
    bit          drain_req;
    logic        nxt_valid;
    gov_req_t    r;
    nxt_valid = in_valid;
    if (in_count != seen_in) begin
      seen_in = in_count;
      nxt_valid = 1'b0;
    end
    if (rst_ni && !nxt_valid) begin
      if (send_gap != 0) begin
        send_gap--;
      end else if (req_q.size() != 0 && !(drain_req && lock_state_q.size() != 0)) begin
        r = req_q.pop_front();
        req_type     <= r.req_type;
        packet_bytes <= r.packet_bytes;
        nxt_valid = 1'b1;
        send_gap = draw_gap(src_fast);
        sent_count++;
        drain_req = (sent_count % 150 == 75) || ($urandom_range(0, 59) == 0);
      end
    end
    in_valid <= nxt_valid;
  end

  // Receiver: after each result transfer, stall for the drawn number of cycles.
  always @(negedge clk_i) begin : stall_proc
    int unsigned seen_out;
    int unsigned hold_left;
    if (out_count != seen_out) begin
      seen_out = out_count;
      hold_left = draw_gap(sink_fast);
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: check the result transfer first, then predict for the input
  // transfer of the same edge, so a fresh prediction is never matched early.
  always @(posedge clk_i) begin : monitor_proc
    gov_result_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        out_count++;
        if (lock_state_q.size() == 0) begin
          report_error("result transfer with no item outstanding");
        end else begin
          want = lock_state_q.pop_front();
          check_field("lock_active", 64'(lock_active), 64'(want.lock_active));
          check_field("lock_tier", 64'(lock_tier), 64'(want.lock_tier));
          check_field("ddr_lock_active", 64'(ddr_lock_active), 64'(want.ddr_lock_active));
          check_field("cpu_min_khz", 64'(cpu_min_khz), 64'(want.cpu_min_khz));
          check_field("ddr_min_khz", 64'(ddr_min_khz), 64'(want.ddr_min_khz));
          check_field("speed_valid", 64'(speed_valid), 64'(want.speed_valid));
          check_field("measured_kbps", 64'(measured_kbps), 64'(want.measured_kbps));
          check_field("level_changed", 64'(level_changed), 64'(want.level_changed));
        end
      end
      if (in_valid && !in_stall) begin
        in_count++;
        lock_state_q.push_back(step_governor(req_type, packet_bytes));
      end
    end
  end

  initial begin : stim_proc
    logic [tflg_pkg::CfgDataW-1:0] trig;
    logic [tflg_pkg::KbpsW-1:0]    t1;
    logic [tflg_pkg::KbpsW-1:0]    t2;
    logic [tflg_pkg::KbpsW-1:0]    t3;
    logic [tflg_pkg::TimeoutW-1:0] rel;
    logic [tflg_pkg::LevelW-1:0]   ddr;
    int unsigned                   tick_pct;
    int unsigned                   n_items;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: small trigger, thresholds 4000/5000/100000 kbit/s and a
    // two-tick release so every level, the release and the ddr split show up.
    program_regs(24'd1000, 20'd4000, 20'd5000, 20'd100000, 16'd2, 2'd2);
    push_req(tflg_pkg::ReqPacket, 16'd0);       // empty packet, below trigger
    push_req(tflg_pkg::ReqPacket, 16'hFFFF);    // over trigger with no elapsed time
    push_req(tflg_pkg::ReqTick, 16'hFFFF);      // tick while unlocked
    push_req(tflg_pkg::ReqPacket, 16'd1001);    // 8008 kbit/s: level two, ddr on
    push_req(tflg_pkg::ReqTick, 16'd0);
    push_req(tflg_pkg::ReqTick, 16'd0);         // countdown runs out: release
    push_req(tflg_pkg::ReqPacket, 16'd1001);    // 4004 kbit/s: level one, no ddr
    push_req(tflg_pkg::ReqTick, 16'd0);
    push_req(tflg_pkg::ReqTick, 16'd0);
    push_req(tflg_pkg::ReqTick, 16'd0);
    push_req(tflg_pkg::ReqPacket, 16'd1001);    // 2669 kbit/s: below every threshold
    push_req(tflg_pkg::ReqTick, 16'd0);
    push_req(tflg_pkg::ReqPacket, 16'hFFFF);    // top level, ddr on
    push_req(tflg_pkg::ReqPacket, 16'd500);     // leave bytes behind below the trigger
    push_req(tflg_pkg::ReqTick, 16'd0);
    settle();
    // Drop the trigger to zero: an empty packet now fires on the leftover
    // bytes, landing exactly on the first threshold.
    write_reg(tflg_pkg::RegTriggerBytes, '0);
    push_req(tflg_pkg::ReqPacket, 16'd0);
    push_req(tflg_pkg::ReqTick, 16'd0);         // release
    push_req(tflg_pkg::ReqPacket, 16'd0);       // nothing accumulated, no trigger
    push_req(tflg_pkg::ReqTick, 16'd0);
    push_req(tflg_pkg::ReqPacket, 16'hFFFF);
    settle();

    // Random phases, each with its own register set and traffic mix.
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 1) trig = '0;
      else if (ph == 3) trig = '1;
      else trig = tflg_pkg::CfgDataW'($urandom_range(100, 300000));
      if (ph == 4) begin
        t1 = '0; t2 = '0; t3 = '0;
      end else if (ph == 6) begin
        t1 = '1; t2 = '1; t3 = '1;
      end else if (ph == 8) begin
        // Unordered thresholds: the scan must stop at the first miss.
        t1 = tflg_pkg::KbpsW'($urandom_range(0, 400000));
        t2 = tflg_pkg::KbpsW'($urandom_range(0, 400000));
        t3 = tflg_pkg::KbpsW'($urandom_range(0, 400000));
      end else begin
        t1 = tflg_pkg::KbpsW'($urandom_range(0, 150000));
        t2 = t1 + tflg_pkg::KbpsW'($urandom_range(0, 150000));
        t3 = t2 + tflg_pkg::KbpsW'($urandom_range(0, 300000));
      end
      if (ph % 3 == 0) rel = 16'd1;
      else if (ph % 3 == 1) rel = '1;
      else rel = tflg_pkg::TimeoutW'($urandom_range(2, 40));
      if (ph == 0) ddr = 2'd1;
      else if (ph == 1) ddr = 2'd3;
      else ddr = tflg_pkg::LevelW'($urandom_range(1, 3));
      program_regs(trig, t1, t2, t3, rel, ddr);

      src_fast  = (ph == 2) || ($urandom_range(0, 3) == 0);
      sink_fast = (ph == 2) || ($urandom_range(0, 3) == 0);
      tick_pct = $urandom_range(5, 60);
      n_items = 105;
      // Full-scale trigger needs a long run of maximum packets to fire.
      if (ph == 3) begin
        tick_pct = 3;
        n_items = 360;
      end
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 99) < tick_pct)
          push_req(tflg_pkg::ReqTick, tflg_pkg::PktBytesW'($urandom));
        else if (ph == 3 && $urandom_range(0, 9) != 0)
          push_req(tflg_pkg::ReqPacket, '1);
        else
          push_req(tflg_pkg::ReqPacket, pick_len(trig));
      end
      settle();
    end

    if (lock_state_q.size() != 0) report_error("results outstanding at end of run");
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog_proc
    #(10_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tflg_pkg.sv
rtl/core/throughput_frequency_lock_governor.sv
verif/tb_throughput_frequency_lock_governor.sv
